>>> rtl/core/mrfd_pkg.sv
// Shared types, constants and the CRC-16 byte step for the meter reply decoder.
package mrfd_pkg;

	localparam int unsigned FRAME_LEN = 25;
	localparam int unsigned PAY_FIRST = 3;
	localparam int unsigned PAY_LEN = FRAME_LEN - PAY_FIRST - 2;

	typedef logic [4:0] pos_t;

	localparam pos_t PayFirstPos = pos_t'(PAY_FIRST);
	localparam pos_t CrcLoPos = pos_t'(FRAME_LEN - 2);
	localparam pos_t CrcHiPos = pos_t'(FRAME_LEN - 1);

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef struct packed {
		logic payload_en;
		logic done;
		logic ok;
	} frame_ev_t;

	typedef struct packed {
		logic [15:0] voltage_raw;
		logic [31:0] current_raw;
		logic [31:0] power_raw;
		logic [31:0] energy_raw;
		logic [15:0] frequency_raw;
		logic [15:0] power_factor_raw;
		logic [15:0] alarm_word;
	} meas_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

>>> rtl/core/mrfd_byte_if.sv
// Byte request channel of the meter reply decoder.
interface mrfd_byte_if;
	logic valid;
	logic ready;
	logic [7:0] rx_byte;
	logic frame_start;

	modport source(output valid, output rx_byte, output frame_start, input ready);
	modport sink(input valid, input rx_byte, input frame_start, output ready);
endinterface

>>> rtl/core/mrfd_meas_if.sv
// Measurement result channel of the meter reply decoder.
interface mrfd_meas_if;
	logic valid;
	logic ready;
	logic crc_ok;
	logic [15:0] voltage_raw;
	logic [31:0] current_raw;
	logic [31:0] power_raw;
	logic [31:0] energy_raw;
	logic [15:0] frequency_raw;
	logic [15:0] power_factor_raw;
	logic [15:0] alarm_word;

	modport source(output valid, output crc_ok, output voltage_raw, output current_raw,
		output power_raw, output energy_raw, output frequency_raw,
		output power_factor_raw, output alarm_word, input ready);
	modport sink(input valid, input crc_ok, input voltage_raw, input current_raw,
		input power_raw, input energy_raw, input frequency_raw,
		input power_factor_raw, input alarm_word, output ready);
endinterface

>>> rtl/core/meter_response_frame_decoder.sv
// Top level of the 25-byte meter reply decoder with CRC-16 check.
// Each byte is first registered in the byte stage; the result register is loaded from the frame's last byte there.
// Throughput: one byte per cycle; the byte stage stalls only when a result waits.
// A result is one register deep and is held until taken; held values only change then.
// Reset clears the frame position, the held words and both valid flags, and sets the CRC to its initial value.
module meter_response_frame_decoder (
	input  logic           clk,
	input  logic           arst_n,
	mrfd_byte_if.sink      frame,
	mrfd_meas_if.source    meas
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                start_s1;
	logic                out_valid_q;
	logic                crc_ok_q;
	logic                out_free;
	logic                adv;
	logic                step;
	mrfd_pkg::frame_ev_t ev;
	mrfd_pkg::meas_t     vals;

	assign out_free = !out_valid_q || meas.ready;
	assign adv = valid_s1 && (!ev.done || out_free);
	assign step = adv;
	assign frame.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.valid && frame.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.valid && frame.ready) begin
			byte_s1 <= frame.rx_byte;
			start_s1 <= frame.frame_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			crc_ok_q <= 1'b0;
		end else if (adv && ev.done) begin
			out_valid_q <= 1'b1;
			crc_ok_q <= ev.ok;
		end else if (meas.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	mrfd_frame u_frame (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.rx_byte(byte_s1),
		.frame_start(start_s1),
		.ev(ev)
	);

	mrfd_hold u_hold (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.rx_byte(byte_s1),
		.ev(ev),
		.vals(vals)
	);

	assign meas.valid = out_valid_q;
	assign meas.crc_ok = crc_ok_q;
	assign meas.voltage_raw = vals.voltage_raw;
	assign meas.current_raw = vals.current_raw;
	assign meas.power_raw = vals.power_raw;
	assign meas.energy_raw = vals.energy_raw;
	assign meas.frequency_raw = vals.frequency_raw;
	assign meas.power_factor_raw = vals.power_factor_raw;
	assign meas.alarm_word = vals.alarm_word;

endmodule

>>> rtl/core/mrfd_frame.sv
// Frame position counter, running CRC-16 and received CRC compare.
module mrfd_frame (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             rx_byte,
	input  logic                   frame_start,
	output mrfd_pkg::frame_ev_t    ev
);

	mrfd_pkg::pos_t count_q;
	logic [15:0]    crc_q;
	logic [7:0]     crc_lo_q;
	mrfd_pkg::pos_t idx;
	logic [15:0]    crc_base;

	assign idx = frame_start ? '0 : count_q;
	assign crc_base = frame_start ? mrfd_pkg::CRC_INIT : crc_q;

	always_comb begin
		ev.done = (idx >= mrfd_pkg::CrcHiPos);
		ev.payload_en = (idx >= mrfd_pkg::PayFirstPos) && (idx < mrfd_pkg::CrcLoPos);
		ev.ok = ({rx_byte, crc_lo_q} == crc_base);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q <= mrfd_pkg::CRC_INIT;
		end else if (step) begin
			if (idx < mrfd_pkg::CrcLoPos) begin
				crc_q <= mrfd_pkg::crc16_byte(crc_base, rx_byte);
				count_q <= idx + 5'd1;
			end else if (idx == mrfd_pkg::CrcLoPos) begin
				crc_q <= crc_base;
				count_q <= idx + 5'd1;
			end else begin
				crc_q <= mrfd_pkg::CRC_INIT;
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && idx == mrfd_pkg::CrcLoPos) begin
			crc_lo_q <= rx_byte;
		end
	end

endmodule

>>> rtl/core/mrfd_hold.sv
// Payload shift line and the held measurement words.
module mrfd_hold (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             rx_byte,
	input  mrfd_pkg::frame_ev_t    ev,
	output mrfd_pkg::meas_t        vals
);

	logic [7:0]      pay_q [mrfd_pkg::PAY_LEN];
	mrfd_pkg::meas_t held_q;
	mrfd_pkg::meas_t fresh;

	always_ff @(posedge clk) begin
		if (step && ev.payload_en) begin
			for (int i = 0; i < mrfd_pkg::PAY_LEN - 1; i++) begin
				pay_q[i] <= pay_q[i + 1];
			end
			pay_q[mrfd_pkg::PAY_LEN - 1] <= rx_byte;
		end
	end

	// 32-bit values arrive low word first, each word high byte first.
	always_comb begin
		fresh.voltage_raw = {pay_q[0], pay_q[1]};
		fresh.current_raw = {pay_q[4], pay_q[5], pay_q[2], pay_q[3]};
		fresh.power_raw = {pay_q[8], pay_q[9], pay_q[6], pay_q[7]};
		fresh.energy_raw = {pay_q[12], pay_q[13], pay_q[10], pay_q[11]};
		fresh.frequency_raw = {pay_q[14], pay_q[15]};
		fresh.power_factor_raw = {pay_q[16], pay_q[17]};
		fresh.alarm_word = {pay_q[18], pay_q[19]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (step && ev.done && ev.ok) begin
			held_q <= fresh;
		end
	end

	assign vals = held_q;

endmodule

>>> rtl/core/mrfd_checker.sv
// Port-level checks of the meter reply decoder and their binding.
module mrfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        out_crc_ok,
	input logic [15:0] out_voltage
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Result request dropped while stalled.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_crc_ok) && $stable(out_voltage))
		else $error("Result payload changed while stalled.");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("Input stalled with no result waiting.");

	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("Result appeared without a byte accepted two cycles before.");

endmodule

bind meter_response_frame_decoder mrfd_checker u_mrfd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(frame.valid),
	.in_ready(frame.ready),
	.out_valid(meas.valid),
	.out_ready(meas.ready),
	.out_crc_ok(meas.crc_ok),
	.out_voltage(meas.voltage_raw)
);

>>> tb/tb_meter_response_frame_decoder.sv
// Testbench for the meter reply decoder: feeds byte requests and checks each result.
module tb_meter_response_frame_decoder;

	typedef struct packed {
		logic crc_ok;
		mrfd_pkg::meas_t m;
	} reading_t;

	typedef enum logic [2:0] {FILL_ZERO, FILL_ONES, FILL_RAMP, FILL_ALT, FILL_RAND} fill_e;

	typedef struct {
		fill_e fill;
		logic bad_crc;
		int unsigned cut;
		logic lead_start;
		logic typed;
		reading_t want;
	} frame_row_t;

	localparam int unsigned RANDOM_BYTES = 1270;
	localparam int unsigned HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n;

	mrfd_byte_if frame();
	mrfd_meas_if meas();

	meter_response_frame_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.frame(frame),
		.meas(meas)
	);

	always #6 clk = ~clk;

	mrfd_pkg::pos_t pos_now;
	logic [15:0] crc_acc;
	logic [7:0] staged [mrfd_pkg::PAY_LEN];
	logic [7:0] crc_lo_seen;
	mrfd_pkg::meas_t held;

	reading_t readings_due [$];
	int errors = 0;
	int unsigned bytes_sent = 0;
	logic [7:0] frame_buf [mrfd_pkg::FRAME_LEN];
	logic tx_eager = 1'b0;
	logic rx_eager = 1'b0;
	int unsigned hold_ticket = 0;

	// A partial frame before a row is cut short by a restart; typed rows carry their result.
	frame_row_t plan_rows [8] = '{
		'{FILL_ZERO, 1'b1, 0, 1'b1, 1'b1, reading_t'({1'b0, 160'h0})},
		'{FILL_ZERO, 1'b0, 0, 1'b1, 1'b1, reading_t'({1'b1, 160'h0})},
		'{FILL_ONES, 1'b0, 0, 1'b1, 1'b1, reading_t'({1'b1, {160{1'b1}}})},
		'{FILL_RAMP, 1'b0, 0, 1'b0, 1'b0, reading_t'('0)},
		'{FILL_RAND, 1'b1, 0, 1'b1, 1'b0, reading_t'('0)},
		'{FILL_ALT, 1'b0, 7, 1'b1, 1'b0, reading_t'('0)},
		'{FILL_RAND, 1'b0, 24, 1'b1, 1'b0, reading_t'('0)},
		'{FILL_RAND, 1'b0, 0, 1'b0, 1'b0, reading_t'('0)}
	};

	function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] v;
		v = c ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (v[0]) begin
				v = (v >> 1) ^ mrfd_pkg::CRC_POLY;
			end else begin
				v = v >> 1;
			end
		end
		return v;
	endfunction

	function automatic logic decode_byte(input logic [7:0] b, input logic s, output reading_t r);
		logic ok;
		r = '0;
		if (s) begin
			pos_now = '0;
			crc_acc = mrfd_pkg::CRC_INIT;
		end
		if (pos_now < mrfd_pkg::CrcLoPos) begin
			crc_acc = crc_update(crc_acc, b);
			if (pos_now >= mrfd_pkg::PayFirstPos) begin
				staged[pos_now - mrfd_pkg::PayFirstPos] = b;
			end
			pos_now++;
			return 1'b0;
		end
		if (pos_now == mrfd_pkg::CrcLoPos) begin
			crc_lo_seen = b;
			pos_now++;
			return 1'b0;
		end
		ok = ({b, crc_lo_seen} == crc_acc);
		if (ok) begin
			held.voltage_raw = {staged[0], staged[1]};
			held.current_raw = {staged[4], staged[5], staged[2], staged[3]};
			held.power_raw = {staged[8], staged[9], staged[6], staged[7]};
			held.energy_raw = {staged[12], staged[13], staged[10], staged[11]};
			held.frequency_raw = {staged[14], staged[15]};
			held.power_factor_raw = {staged[16], staged[17]};
			held.alarm_word = {staged[18], staged[19]};
		end
		r.crc_ok = ok;
		r.m = held;
		pos_now = '0;
		crc_acc = mrfd_pkg::CRC_INIT;
		return 1'b1;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] rand_byte();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10) begin
			return 8'h00;
		end
		if (r < 20) begin
			return 8'hFF;
		end
		return 8'($urandom_range(255));
	endfunction

	function automatic void build_frame(input fill_e fill);
		logic [15:0] c;
		c = mrfd_pkg::CRC_INIT;
		for (int i = 0; i < mrfd_pkg::FRAME_LEN - 2; i++) begin
			case (fill)
				FILL_ZERO: frame_buf[i] = 8'h00;
				FILL_ONES: frame_buf[i] = 8'hFF;
				FILL_RAMP: frame_buf[i] = 8'(i * 9 + 3);
				FILL_ALT: frame_buf[i] = i[0] ? 8'h55 : 8'hAA;
				default: frame_buf[i] = rand_byte();
			endcase
			c = crc_update(c, frame_buf[i]);
		end
		frame_buf[mrfd_pkg::CrcLoPos] = c[7:0];
		frame_buf[mrfd_pkg::CrcHiPos] = c[15:8];
	endfunction

	function automatic void check_field(input string what, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			errors++;
			$display("%0t %s mismatch: expected %h actual %h", $time, what, exp_v, act_v);
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic s, output logic produced);
		int unsigned gap;
		reading_t r;
		gap = tx_eager ? 0 : pick_gap();
		if (gap != 0) begin
			frame.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame.valid <= 1'b1;
		frame.rx_byte <= b;
		frame.frame_start <= s;
		do @(posedge clk); while (!frame.ready);
		produced = decode_byte(b, s, r);
		if (produced) begin
			readings_due.push_back(r);
		end
		bytes_sent++;
	endtask

	task automatic send_frame(input int unsigned count, input logic lead_start,
		output logic produced);
		for (int i = 0; i < count; i++) begin
			send_byte(frame_buf[i], (i == 0) && lead_start, produced);
		end
	endtask

	initial begin
		frame_row_t row;
		logic produced;
		int unsigned r;
		int unsigned n;
		int unsigned stop_at;
		int unsigned flip_byte;
		int unsigned flip_bit;
		arst_n <= 1'b0;
		frame.valid <= 1'b0;
		frame.rx_byte <= 8'h00;
		frame.frame_start <= 1'b0;
		pos_now = '0;
		crc_acc = mrfd_pkg::CRC_INIT;
		crc_lo_seen = '0;
		held = '0;
		foreach (staged[k]) begin
			staged[k] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan_rows[k]) begin
			row = plan_rows[k];
			if (row.cut != 0) begin
				build_frame(FILL_RAND);
				send_frame(row.cut, 1'b1, produced);
			end
			build_frame(row.fill);
			if (row.bad_crc) begin
				frame_buf[mrfd_pkg::CrcHiPos] ^= 8'h01;
			end
			send_frame(mrfd_pkg::FRAME_LEN, row.lead_start, produced);
			if (row.typed && produced) begin
				readings_due[readings_due.size() - 1] = row.want;
			end
		end

		stop_at = bytes_sent + RANDOM_BYTES;
		n = 0;
		while (bytes_sent < stop_at) begin
			if (n == 20) begin
				hold_ticket <= hold_ticket + 1;
			end
			if (n == 40 && readings_due.size() != 0) begin
				frame.valid <= 1'b0;
				while (readings_due.size() != 0) @(posedge clk);
			end
			tx_eager = (n >= 50) && (n < 58);
			rx_eager <= tx_eager;
			r = $urandom_range(99);
			if (r < 60) begin
				build_frame(FILL_RAND);
				send_frame(mrfd_pkg::FRAME_LEN, (pos_now != 0) || ($urandom_range(1) != 0),
					produced);
			end else if (r < 75) begin
				build_frame(FILL_RAND);
				flip_byte = $urandom_range(mrfd_pkg::FRAME_LEN - 1);
				flip_bit = $urandom_range(7);
				frame_buf[flip_byte][flip_bit] = ~frame_buf[flip_byte][flip_bit];
				send_frame(mrfd_pkg::FRAME_LEN, 1'b1, produced);
			end else if (r < 87) begin
				build_frame(FILL_RAND);
				send_frame($urandom_range(1, mrfd_pkg::FRAME_LEN - 1), 1'b1, produced);
			end else begin
				repeat ($urandom_range(1, 8)) begin
					send_byte(rand_byte(), $urandom_range(3) == 0, produced);
				end
			end
			n++;
		end
		frame.valid <= 1'b0;

		while (readings_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		int unsigned hold_left;
		int unsigned stall_left;
		int unsigned hold_seen;
		int unsigned r;
		reading_t got;
		reading_t want;
		hold_left = 0;
		stall_left = 0;
		hold_seen = 0;
		meas.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (meas.valid && meas.ready) begin
				got = {meas.crc_ok, meas.voltage_raw, meas.current_raw, meas.power_raw,
					meas.energy_raw, meas.frequency_raw, meas.power_factor_raw, meas.alarm_word};
				if (readings_due.size() == 0) begin
					errors++;
					$display("%0t unexpected result: expected none actual %h", $time, got);
				end else begin
					want = readings_due.pop_front();
					check_field("crc_ok", 32'(want.crc_ok), 32'(got.crc_ok));
					check_field("voltage_raw", 32'(want.m.voltage_raw), 32'(got.m.voltage_raw));
					check_field("current_raw", want.m.current_raw, got.m.current_raw);
					check_field("power_raw", want.m.power_raw, got.m.power_raw);
					check_field("energy_raw", want.m.energy_raw, got.m.energy_raw);
					check_field("frequency_raw", 32'(want.m.frequency_raw),
						32'(got.m.frequency_raw));
					check_field("power_factor_raw", 32'(want.m.power_factor_raw),
						32'(got.m.power_factor_raw));
					check_field("alarm_word", 32'(want.m.alarm_word), 32'(got.m.alarm_word));
				end
			end
			if (hold_ticket != hold_seen) begin
				hold_seen = hold_ticket;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				meas.ready <= 1'b0;
				hold_left--;
			end else if (stall_left != 0) begin
				meas.ready <= 1'b0;
				stall_left--;
			end else if (rx_eager) begin
				meas.ready <= 1'b1;
			end else begin
				r = $urandom_range(99);
				if (r < 65) begin
					meas.ready <= 1'b1;
				end else begin
					meas.ready <= 1'b0;
					stall_left = (r < 95) ? $urandom_range(2) : $urandom_range(10, 40);
				end
			end
		end
	end

	initial begin
		#7200000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
